// ===== rtl/bdx_pkg.sv =====
// shared types and constants for the bit deposit / extract unit
// no dependencies
`default_nettype none

package bdx_pkg;

    // width of the payload ports
    localparam int FIELD_BITS = 64;

    // default data path width
    localparam int WORD_BITS_DEFAULT = 64;

    typedef enum logic [0:0] {
        OP_DEPOSIT = 1'b0,
        OP_EXTRACT = 1'b1
    } opcode_t;

endpackage

`default_nettype wire

// ===== rtl/bdx_zero_count.sv =====
// per bit position, the number of clear mask bits below that position
// parallel prefix count in log2(WORD_BITS) levels; uses bdx_pkg
`default_nettype none

module bdx_zero_count #(
    parameter int WORD_BITS = bdx_pkg::WORD_BITS_DEFAULT
) (
    input  logic [WORD_BITS-1:0]                         mask,
    output logic [WORD_BITS-1:0][$clog2(WORD_BITS)-1:0] zeros_below
);

    localparam int LOG_W = $clog2(WORD_BITS);

    logic [WORD_BITS-1:0][LOG_W-1:0] acc [0:LOG_W];

    always_comb
    begin
        // exclusive count: seed with the clear bit just below each position
        acc[0][0] = '0;
        for (int i = 1; i < WORD_BITS; i++)
        begin
            acc[0][i] = LOG_W'(!mask[i-1]);
        end
        for (int s = 0; s < LOG_W; s++)
        begin
            for (int i = 0; i < WORD_BITS; i++)
            begin
                if (i >= (1 << s))
                begin
                    acc[s+1][i] = LOG_W'(acc[s][i] + acc[s][i-(1 << s)]);
                end
                else
                begin
                    acc[s+1][i] = acc[s][i];
                end
            end
        end
    end

    assign zeros_below = acc[LOG_W];

endmodule

`default_nettype wire

// ===== rtl/bdx_compress_net.sv =====
// compress network: moves each masked bit down by its zero count, one
// power of two per level, and records the per-level move masks; uses bdx_pkg
`default_nettype none

module bdx_compress_net #(
    parameter int WORD_BITS = bdx_pkg::WORD_BITS_DEFAULT
) (
    input  logic [WORD_BITS-1:0]                         source,
    input  logic [WORD_BITS-1:0]                         mask,
    input  logic [WORD_BITS-1:0][$clog2(WORD_BITS)-1:0] zeros_below,
    output logic [$clog2(WORD_BITS)-1:0][WORD_BITS-1:0] move_mask,
    output logic [WORD_BITS-1:0]                         extracted
);

    localparam int LOG_W = $clog2(WORD_BITS);

    logic [WORD_BITS-1:0]            live [0:LOG_W];
    logic [WORD_BITS-1:0]            data [0:LOG_W];
    logic [WORD_BITS-1:0][LOG_W-1:0] hop [0:LOG_W];

    always_comb
    begin
        logic stay;
        stay    = 1'b0;
        live[0] = mask;
        data[0] = source & mask;
        hop[0]  = zeros_below;
        for (int j = 0; j < LOG_W; j++)
        begin
            for (int q = 0; q < WORD_BITS; q++)
            begin
                move_mask[j][q] = live[j][q] & hop[j][q][j];
            end
            for (int q = 0; q < WORD_BITS; q++)
            begin
                stay = live[j][q] & !hop[j][q][j];
                if (stay)
                begin
                    live[j+1][q] = 1'b1;
                    data[j+1][q] = data[j][q];
                    hop[j+1][q]  = hop[j][q];
                end
                else if ((q + (1 << j) < WORD_BITS) && move_mask[j][q + (1 << j)])
                begin
                    live[j+1][q] = 1'b1;
                    data[j+1][q] = data[j][q + (1 << j)];
                    hop[j+1][q]  = hop[j][q + (1 << j)];
                end
                else
                begin
                    live[j+1][q] = 1'b0;
                    data[j+1][q] = 1'b0;
                    hop[j+1][q]  = '0;
                end
            end
        end
    end

    assign extracted = data[LOG_W];

endmodule

`default_nettype wire

// ===== rtl/bdx_expand_net.sv =====
// expand network: runs the compress moves backwards, highest level first,
// to spread low source bits out to the mask positions; uses bdx_pkg
`default_nettype none

module bdx_expand_net #(
    parameter int WORD_BITS = bdx_pkg::WORD_BITS_DEFAULT
) (
    input  logic [WORD_BITS-1:0]                         source,
    input  logic [$clog2(WORD_BITS)-1:0][WORD_BITS-1:0] move_mask,
    output logic [WORD_BITS-1:0]                         deposited
);

    localparam int LOG_W = $clog2(WORD_BITS);

    logic [WORD_BITS-1:0] spread [0:LOG_W];

    always_comb
    begin
        spread[LOG_W] = source;
        for (int j = LOG_W - 1; j >= 0; j--)
        begin
            for (int q = 0; q < WORD_BITS; q++)
            begin
                // a set move bit always sits at or above its shift distance
                if (move_mask[j][q] && (q >= (1 << j)))
                begin
                    spread[j][q] = spread[j+1][q - (1 << j)];
                end
                else
                begin
                    spread[j][q] = spread[j+1][q];
                end
            end
        end
    end

    // positions outside the mask may carry leftovers; the top level masks them
    assign deposited = spread[0];

endmodule

`default_nettype wire

// ===== rtl/bit_deposit_extract_unit_core.sv =====
// top level of the bit deposit / extract unit: handshake, input and result registers
// depends on bdx_pkg, bdx_zero_count, bdx_compress_net, bdx_expand_net
`default_nettype none

// Parallel bit deposit (opcode 0) and extract (opcode 1) over the low WORD_BITS
// bits of source_bits and select_mask; result bits at and above WORD_BITS are zero.
// The unit accepts one word per cycle while results are not stalled; each word is held
// in an input register and then in a result register, so a waiting result does not
// stop one more word from entering an empty input register. The clock period
// is set by the single pass between those registers: a log2(WORD_BITS)-level
// prefix count of clear mask bits, then log2(WORD_BITS) levels of the compress
// network and, for deposit, log2(WORD_BITS) levels of the expand network.
// There is no state beyond the pipeline and no configuration.

module bit_deposit_extract_unit_core #(
    parameter int WORD_BITS = bdx_pkg::WORD_BITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            opcode,
    input  logic [bdx_pkg::FIELD_BITS-1:0] source_bits,
    input  logic [bdx_pkg::FIELD_BITS-1:0] select_mask,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [bdx_pkg::FIELD_BITS-1:0] result_bits
);

    localparam int LOG_W = $clog2(WORD_BITS);

    logic                 s1_valid_reg;
    bdx_pkg::opcode_t     s1_op_reg;
    logic [WORD_BITS-1:0] s1_src_reg;
    logic [WORD_BITS-1:0] s1_mask_reg;

    logic                            out_valid_reg;
    logic [bdx_pkg::FIELD_BITS-1:0] result_reg;
    logic [bdx_pkg::FIELD_BITS-1:0] result_next;

    logic                            out_free;
    logic                            s1_advance;

    logic [WORD_BITS-1:0][LOG_W-1:0] zeros_below;
    logic [LOG_W-1:0][WORD_BITS-1:0] move_mask;
    logic [WORD_BITS-1:0]            extracted;
    logic [WORD_BITS-1:0]            deposited;
    logic [WORD_BITS-1:0]            result_calc;

    assign out_free   = !out_valid_reg || out_ready;
    assign s1_advance = s1_valid_reg && out_free;
    assign in_ready   = !s1_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_op_reg   <= bdx_pkg::opcode_t'(opcode);
            s1_src_reg  <= source_bits[WORD_BITS-1:0];
            s1_mask_reg <= select_mask[WORD_BITS-1:0];
        end
    end

    bdx_zero_count #(
        .WORD_BITS (WORD_BITS)
    ) u_zero_count (
        .mask        (s1_mask_reg),
        .zeros_below (zeros_below)
    );

    bdx_compress_net #(
        .WORD_BITS (WORD_BITS)
    ) u_compress_net (
        .source      (s1_src_reg),
        .mask        (s1_mask_reg),
        .zeros_below (zeros_below),
        .move_mask   (move_mask),
        .extracted   (extracted)
    );

    bdx_expand_net #(
        .WORD_BITS (WORD_BITS)
    ) u_expand_net (
        .source    (s1_src_reg),
        .move_mask (move_mask),
        .deposited (deposited)
    );

    always_comb
    begin
        case (s1_op_reg)
            bdx_pkg::OP_EXTRACT: result_calc = extracted;
            bdx_pkg::OP_DEPOSIT: result_calc = deposited & s1_mask_reg;
            default:             result_calc = '0;
        endcase
        result_next = bdx_pkg::FIELD_BITS'(result_calc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_bits = result_reg;

    // full input stage behind a stalled result must hold off new words
    a_stall_blocks_input: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !out_ready) |-> !in_ready
    ) else $error("input taken while both stages are full and stalled");

    // an accepted word is held in the input stage on the next cycle
    a_accept_fills_stage: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> s1_valid_reg
    ) else $error("accepted word lost before the input stage");

    // a word leaving the input stage shows up as a result
    a_advance_fills_out: assert property (
        @(posedge clk) disable iff (!rst_n)
        s1_advance |=> out_valid_reg
    ) else $error("word lost between input stage and result register");

    // both operations move bits without creating any
    a_count_bound: assert property (
        @(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> ($countones(result_calc) <= $countones(s1_mask_reg))
    ) else $error("result has more set bits than the mask");

    // nothing above the word width
    a_upper_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((result_reg >> WORD_BITS) == '0)
    ) else $error("result bits set above the word width");

endmodule

`default_nettype wire

// ===== tb/sv/bit_deposit_extract_unit_core_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for bit_deposit_extract_unit_core: directed and random
// deposit / extract words under several idling patterns; depends on bdx_pkg and the core

module bit_deposit_extract_unit_core_tb;

    localparam int  DATA_BITS   = bdx_pkg::WORD_BITS_DEFAULT;
    localparam int  PHASE_WORDS = 300;
    localparam int  DRAIN_CYCLES = 8;
    localparam int  MAX_PRINTS  = 40;
    localparam longint CYCLE_LIMIT = 400000;

    typedef logic [bdx_pkg::FIELD_BITS-1:0] word_t;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  in_valid = 1'b0;
    logic  opcode = bdx_pkg::OP_DEPOSIT;
    word_t source_bits = '0;
    word_t select_mask = '0;
    logic  out_ready = 1'b0;
    logic  in_ready;
    logic  out_valid;
    word_t result_bits;

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int          fail_count = 0;
    longint      cycle_count = 0;
    word_t       expected_results[$];

    bit_deposit_extract_unit_core #(
        .WORD_BITS(DATA_BITS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .opcode(opcode),
        .source_bits(source_bits),
        .select_mask(select_mask),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .result_bits(result_bits)
    );

    always #1 clk = ~clk;

    function automatic word_t width_mask();
        word_t m;
        m = '0;
        for (int i = 0; i < DATA_BITS; i++)
            m[i] = 1'b1;
        return m;
    endfunction

    // low source bits land on the set mask positions, lowest first
    function automatic word_t deposit_bits(input word_t src, input word_t msk);
        word_t res;
        int    k;
        res = '0;
        k = 0;
        for (int i = 0; i < DATA_BITS; i++)
            if (msk[i])
            begin
                res[i] = src[k];
                k++;
            end
        return res;
    endfunction

    // source bits under the set mask positions packed toward bit 0
    function automatic word_t extract_bits(input word_t src, input word_t msk);
        word_t res;
        int    k;
        res = '0;
        k = 0;
        for (int i = 0; i < DATA_BITS; i++)
            if (msk[i])
            begin
                res[k] = src[i];
                k++;
            end
        return res;
    endfunction

    function automatic word_t predict_result(input bdx_pkg::opcode_t op, input word_t src,
                                             input word_t msk);
        word_t wm;
        wm = width_mask();
        if (op == bdx_pkg::OP_EXTRACT)
            return extract_bits(src & wm, msk & wm) & wm;
        return deposit_bits(src & wm, msk & wm) & wm;
    endfunction

    function automatic word_t random_word();
        return {$urandom, $urandom};
    endfunction

    // masks of varied density so that both sparse and dense packings occur
    function automatic word_t random_mask();
        int    lo;
        int    len;
        word_t run;
        case ($urandom_range(5))
            0: return random_word() & random_word() & random_word();
            1: return random_word() | random_word();
            2:
            begin
                lo = $urandom_range(bdx_pkg::FIELD_BITS - 1);
                len = $urandom_range(bdx_pkg::FIELD_BITS - lo, 1);
                run = '0;
                for (int i = 0; i < len; i++)
                    run[lo + i] = 1'b1;
                return run;
            end
            3: return ($urandom_range(3) == 0) ? '0 : ~word_t'(0);
            default: return random_word();
        endcase
    endfunction

    task automatic report_mismatch(input string what, input word_t got, input word_t want);
        if (fail_count < MAX_PRINTS)
            $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
        fail_count++;
    endtask

    // drives one word and returns at the edge where it is taken
    task automatic send_word(input bdx_pkg::opcode_t op, input word_t src, input word_t msk);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            source_bits <= random_word();
            select_mask <= random_word();
            @(negedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        source_bits <= src;
        select_mask <= msk;
        do
            @(posedge clk);
        while (!in_ready);
        expected_results.push_back(predict_result(op, src, msk));
    endtask

    task automatic send_random_words(input int count);
        bdx_pkg::opcode_t op;
        for (int n = 0; n < count; n++)
        begin
            op = ($urandom_range(1) == 1) ? bdx_pkg::OP_EXTRACT : bdx_pkg::OP_DEPOSIT;
            send_word(op, random_word(), random_mask());
        end
    endtask

    task automatic test_corner_words();
        word_t ones;
        ones = ~word_t'(0);
        // empty mask gives zero either way
        send_word(bdx_pkg::OP_DEPOSIT, ones, '0);
        send_word(bdx_pkg::OP_EXTRACT, ones, '0);
        // full mask is the identity
        send_word(bdx_pkg::OP_DEPOSIT, 64'h0123_4567_89ab_cdef, ones);
        send_word(bdx_pkg::OP_EXTRACT, 64'hfedc_ba98_7654_3210, ones);
        send_word(bdx_pkg::OP_DEPOSIT, ones, ones);
        send_word(bdx_pkg::OP_EXTRACT, ones, ones);
        send_word(bdx_pkg::OP_DEPOSIT, '0, ones);
        send_word(bdx_pkg::OP_EXTRACT, '0, ones);
        // single mask bits at both ends
        send_word(bdx_pkg::OP_DEPOSIT, 64'h1, 64'h8000_0000_0000_0000);
        send_word(bdx_pkg::OP_EXTRACT, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
        send_word(bdx_pkg::OP_DEPOSIT, ones, 64'h1);
        send_word(bdx_pkg::OP_EXTRACT, ones, 64'h1);
        // alternating masks
        send_word(bdx_pkg::OP_DEPOSIT, ones, 64'haaaa_aaaa_aaaa_aaaa);
        send_word(bdx_pkg::OP_EXTRACT, 64'haaaa_aaaa_aaaa_aaaa, 64'haaaa_aaaa_aaaa_aaaa);
        send_word(bdx_pkg::OP_DEPOSIT, 64'h0000_0000_ffff_0f0f, 64'h5555_5555_5555_5555);
        send_word(bdx_pkg::OP_EXTRACT, 64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555);
        // top half and high-only source bits
        send_word(bdx_pkg::OP_DEPOSIT, 64'h0000_0000_dead_beef, 64'hffff_ffff_0000_0000);
        send_word(bdx_pkg::OP_EXTRACT, 64'hdead_beef_0000_0000, 64'hffff_ffff_0000_0000);
        send_word(bdx_pkg::OP_DEPOSIT, 64'hffff_ffff_0000_0000, 64'h0000_0000_ffff_ffff);
        send_word(bdx_pkg::OP_EXTRACT, 64'h8000_0000_0000_0001, 64'h8000_0000_0000_0001);
    endtask

    task automatic test_back_to_back();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_random_words(PHASE_WORDS);
    endtask

    task automatic test_sender_gaps();
        send_idle_pct = 73;
        recv_stall_pct = 0;
        send_random_words(PHASE_WORDS);
    endtask

    task automatic test_receiver_stalls();
        send_idle_pct = 0;
        recv_stall_pct = 73;
        send_random_words(PHASE_WORDS);
    endtask

    task automatic test_mixed_idling();
        send_idle_pct = 24;
        recv_stall_pct = 24;
        send_random_words(PHASE_WORDS);
    endtask

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin : check_results
        word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
                report_mismatch("result with no word outstanding", result_bits, '0);
            else
            begin
                want = expected_results.pop_front();
                if (result_bits !== want)
                    report_mismatch("result_bits", result_bits, want);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_corner_words();
        test_back_to_back();
        test_sender_gaps();
        test_receiver_stalls();
        test_mixed_idling();

        @(negedge clk);
        in_valid <= 1'b0;
        recv_stall_pct = 0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/bdx_pkg.sv
rtl/bdx_zero_count.sv
rtl/bdx_compress_net.sv
rtl/bdx_expand_net.sv
rtl/bit_deposit_extract_unit_core.sv
tb/sv/bit_deposit_extract_unit_core_tb.sv
